// File: design/tmg_pkg.sv
// Shared constants and trigonometry helpers for the torus mesh generator.
`default_nettype none

package tmg_pkg;

  // Grid defaults
  localparam int MAJOR_SEGMENTS_DEF = 32;
  localparam int MINOR_SEGMENTS_DEF = 16;

  // Input field widths
  localparam int MAJOR_STEP_W = 6;
  localparam int MINOR_STEP_W = 5;
  localparam int IN_TDATA_W   = 16;

  // Result field widths and positions in out_tdata
  localparam int POS_W        = 18;
  localparam int NORM_W       = 16;
  localparam int TEX_W        = 17;
  localparam int VIDX_W       = 12;
  localparam int TEX_U_LSB    = 102;
  localparam int TEX_V_LSB    = 119;
  localparam int OUT_IDX_LSB  = 136;
  localparam int OUT_TDATA_W  = 152;

  // Fixed-point formats
  localparam int TRIG_W       = 16;   // Q1.14 signed
  localparam int RADIUS_W     = 16;   // Q8.8 unsigned
  localparam int RING_W       = 32;
  localparam int PROD_W       = 48;

  // Quad expansion
  localparam int QUAD_BEATS   = 6;
  localparam int BEAT_W       = 3;

  // Configuration port
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam logic REG_MAJOR  = 1'b0;
  localparam logic REG_MINOR  = 1'b1;
  localparam logic [RADIUS_W-1:0] MAJOR_RADIUS_RST = 16'd256;
  localparam logic [RADIUS_W-1:0] MINOR_RADIUS_RST = 16'd64;

  // Quarter-wave sine, Q1.14, steps of 1/64 turn
  localparam logic [14:0] QUARTER_SINE [17] = '{
    15'd0,     15'd1606,  15'd3196,  15'd4756,  15'd6270,  15'd7723,
    15'd9102,  15'd10394, 15'd11585, 15'd12665, 15'd13623, 15'd14449,
    15'd15137, 15'd15679, 15'd16069, 15'd16305, 15'd16384
  };

  // Sine over the first quarter turn, p in 0..16384, linear interpolation
  function automatic logic [14:0] sine_quarter(input logic [14:0] p);
    logic [4:0]  i;
    logic [9:0]  f;
    logic [10:0] d;
    logic [20:0] t;
    logic [14:0] res;
    i = p[14:10];
    f = p[9:0];
    if (i >= 5'd16) begin
      res = 15'd16384;
    end else begin
      d   = 11'(QUARTER_SINE[i + 5'd1] - QUARTER_SINE[i]);
      t   = 21'(d) * 21'(f) + 21'd512;
      res = QUARTER_SINE[i] + 15'(t >> 10);
    end
    return res;
  endfunction

  // Phase in 1/65536 turn
  function automatic logic signed [TRIG_W-1:0] sine_of(input logic [15:0] ph);
    logic [1:0]  q;
    logic [14:0] p;
    logic [14:0] m;
    q = ph[15:14];
    p = {1'b0, ph[13:0]};
    case (q)
      2'd0, 2'd2: m = sine_quarter(p);
      default:    m = sine_quarter(15'd16384 - p);
    endcase
    return q[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic signed [TRIG_W-1:0] cosine_of(input logic [15:0] ph);
    return sine_of(ph + 16'd16384);
  endfunction

endpackage

`default_nettype wire

// File: design/torus_mesh_generator.sv
// Torus mesh generator: trig table lookup, fixed-point vertex pipeline and quad expansion.
//
// Usage:
//   in_*  : one beat per grid cell. in_tuser = action (0 vertex, 1 quad),
//           in_tdata = {minor_step, major_step}.
//   out_* : result beats. out_tuser = bad_cell, out_tlast = last_of_run.
//   cfg_* : APB-style register port, major radius at 0x0, minor radius at 0x4.
//           Write the radii only while the block is idle.
// A result reaches out_* through the four registered stages once its input beat is taken.
// Throughput: a vertex request or an out-of-grid cell gives one beat and the block
// takes one input beat per cycle while out_tready holds. A quad request gives six
// beats, one per cycle while out_tready holds, so the single output port sets its pace.
// The trig values come from per-step synchronous lookup tables read in the
// accept cycle; two multiply stages and a rounding stage follow.
// Every stage holds its beat while the next one is full, so a stalled receiver
// fills the four stages and then drops in_tready; bubbles close up on the way.
// Reset (synchronous, rst_n low) empties the pipeline and sets the radii to
// 1.0 and 0.25.
`default_nettype none

module torus_mesh_generator #(
  parameter int MAJOR_SEGMENTS = tmg_pkg::MAJOR_SEGMENTS_DEF,
  parameter int MINOR_SEGMENTS = tmg_pkg::MINOR_SEGMENTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [5:0] major_step, [10:6] minor_step, [15:11] zero
  input  wire logic [tmg_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] action
  input  wire logic                              in_tuser,
  // result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [17:0] pos_x, [35:18] pos_y, [53:36] pos_z, [69:54] norm_x, [85:70] norm_y,
  // [101:86] norm_z, [118:102] tex_u, [135:119] tex_v, [147:136] vertex_index,
  // [151:148] zero
  output logic [tmg_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                   out_tlast,
  // [0] bad_cell
  output logic                                   out_tuser,
  // configuration port
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [tmg_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [tmg_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [tmg_pkg::CFG_DATA_W-1:0]         cfg_prdata,
  output logic                                   cfg_pready
);

  import tmg_pkg::*;

  localparam int MAJ_TAB_DEPTH = 2 ** MAJOR_STEP_W;
  localparam int MIN_TAB_DEPTH = 2 ** MINOR_STEP_W;
  localparam int IDX_MAX = MAJOR_SEGMENTS * (MINOR_SEGMENTS + 1) + MINOR_SEGMENTS + 2;
  localparam int IDX_W   = $clog2(IDX_MAX + 1);

  localparam logic [IDX_W-1:0] CORNER_OFS [QUAD_BEATS] = '{
    IDX_W'(0), IDX_W'(1), IDX_W'(MINOR_SEGMENTS + 2),
    IDX_W'(0), IDX_W'(MINOR_SEGMENTS + 2), IDX_W'(MINOR_SEGMENTS + 1)
  };

  // Round to nearest, ties away from zero
  function automatic logic signed [PROD_W-1:0] rnd_half(input logic signed [PROD_W-1:0] v,
                                                         input int s);
    logic signed [PROD_W-1:0] t;
    t = v + (48'sd1 <<< (s - 1));
    if (v[PROD_W-1]) t = t - 48'sd1;
    return t >>> s;
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [PROD_W-1:0] v);
    logic [POS_W-1:0] res;
    if (v < -48'sd131072)     res = 18'h20000;
    else if (v > 48'sd131071) res = 18'h1FFFF;
    else                      res = v[POS_W-1:0];
    return res;
  endfunction

  function automatic logic [NORM_W-1:0] sat_norm(input logic signed [PROD_W-1:0] v);
    logic [NORM_W-1:0] res;
    if (v < -48'sd16384)     res = 16'hC000;
    else if (v > 48'sd16384) res = 16'h4000;
    else                     res = v[NORM_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [RADIUS_W-1:0] major_radius_r;
  logic [RADIUS_W-1:0] minor_radius_r;
  logic                cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      major_radius_r <= MAJOR_RADIUS_RST;
      minor_radius_r <= MINOR_RADIUS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_MAJOR: major_radius_r <= cfg_pwdata[RADIUS_W-1:0];
        REG_MINOR: minor_radius_r <= cfg_pwdata[RADIUS_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_MAJOR: cfg_prdata = CFG_DATA_W'(major_radius_r);
      REG_MINOR: cfg_prdata = CFG_DATA_W'(minor_radius_r);
      default:   cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Per-step lookup tables (constant contents)
  logic [TEX_W-1:0]         maj_u_tab   [MAJ_TAB_DEPTH];
  logic signed [TRIG_W-1:0] maj_cos_tab [MAJ_TAB_DEPTH];
  logic signed [TRIG_W-1:0] maj_sin_tab [MAJ_TAB_DEPTH];
  logic [TEX_W-1:0]         min_u_tab   [MIN_TAB_DEPTH];
  logic signed [TRIG_W-1:0] min_cos_tab [MIN_TAB_DEPTH];
  logic signed [TRIG_W-1:0] min_sin_tab [MIN_TAB_DEPTH];

  for (genvar k = 0; k < MAJ_TAB_DEPTH; k++) begin : g_maj_tab
    localparam int PHASE = (k * 65536 + MAJOR_SEGMENTS / 2) / MAJOR_SEGMENTS;
    assign maj_u_tab[k]   = TEX_W'(PHASE);
    assign maj_cos_tab[k] = cosine_of(16'(PHASE));
    assign maj_sin_tab[k] = sine_of(16'(PHASE));
  end

  for (genvar k = 0; k < MIN_TAB_DEPTH; k++) begin : g_min_tab
    localparam int PHASE = (k * 65536 + MINOR_SEGMENTS / 2) / MINOR_SEGMENTS;
    assign min_u_tab[k]   = TEX_W'(PHASE);
    assign min_cos_tab[k] = cosine_of(16'(PHASE));
    assign min_sin_tab[k] = sine_of(16'(PHASE));
  end

  // ---------------------------------------------------------------------------
  // Handshake chain
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic ld1, ld2, ld3, ld4;
  logic out_last;
  logic out_beat;

  assign rdy4 = !v4_r || (out_tready && out_last);
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign ld1  = in_tvalid & rdy1;
  assign ld2  = v1_r & rdy2;
  assign ld3  = v2_r & rdy3;
  assign ld4  = v3_r & rdy4;

  assign in_tready  = rdy1;
  assign out_tvalid = v4_r;
  assign out_beat   = out_tvalid & out_tready;

  logic [BEAT_W-1:0] beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      beat_r <= '0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (ld4)           beat_r <= '0;
      else if (out_beat) beat_r <= beat_r + BEAT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: grid check, base index, table read
  logic [MAJOR_STEP_W-1:0] in_major;
  logic [MINOR_STEP_W-1:0] in_minor;
  logic                    in_bad;
  logic [IDX_W-1:0]        in_cur;

  assign in_major = in_tdata[MAJOR_STEP_W-1:0];
  assign in_minor = in_tdata[MAJOR_STEP_W +: MINOR_STEP_W];
  assign in_bad   = in_tuser ? (int'(in_major) >= MAJOR_SEGMENTS ||
                                int'(in_minor) >= MINOR_SEGMENTS)
                             : (int'(in_major) > MAJOR_SEGMENTS ||
                                int'(in_minor) > MINOR_SEGMENTS);
  assign in_cur   = IDX_W'(in_major) * IDX_W'(MINOR_SEGMENTS + 1) + IDX_W'(in_minor);

  logic                     s1_act_r, s1_bad_r;
  logic [IDX_W-1:0]         s1_cur_r;
  logic [TEX_W-1:0]         s1_u_r, s1_v_r;
  logic signed [TRIG_W-1:0] s1_ct_r, s1_st_r, s1_cp_r, s1_sp_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_act_r <= in_tuser;
      s1_bad_r <= in_bad;
      s1_cur_r <= in_cur;
      s1_u_r   <= maj_u_tab[in_major];
      s1_ct_r  <= maj_cos_tab[in_major];
      s1_st_r  <= maj_sin_tab[in_major];
      s1_v_r   <= min_u_tab[in_minor];
      s1_cp_r  <= min_cos_tab[in_minor];
      s1_sp_r  <= min_sin_tab[in_minor];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: ring radius in Q.22 and the small products
  logic signed [RING_W:0]   rcp_prod;
  logic signed [RING_W:0]   rsp_prod;
  logic signed [RING_W-1:0] ring_nxt;
  logic signed [RING_W-1:0] cpct_prod, cpst_prod;

  assign rcp_prod  = $signed({1'b0, minor_radius_r}) * s1_cp_r;
  assign rsp_prod  = $signed({1'b0, minor_radius_r}) * s1_sp_r;
  assign ring_nxt  = RING_W'($signed({3'b0, major_radius_r, 14'b0}) + rcp_prod);
  assign cpct_prod = s1_cp_r * s1_ct_r;
  assign cpst_prod = s1_cp_r * s1_st_r;

  logic                     s2_act_r, s2_bad_r;
  logic [IDX_W-1:0]         s2_cur_r;
  logic [TEX_W-1:0]         s2_u_r, s2_v_r;
  logic signed [TRIG_W-1:0] s2_ct_r, s2_st_r, s2_sp_r;
  logic signed [RING_W-1:0] s2_ring_r, s2_cpct_r, s2_cpst_r;
  logic signed [RING_W:0]   s2_rsp_r;

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_act_r  <= s1_act_r;
      s2_bad_r  <= s1_bad_r;
      s2_cur_r  <= s1_cur_r;
      s2_u_r    <= s1_u_r;
      s2_v_r    <= s1_v_r;
      s2_ct_r   <= s1_ct_r;
      s2_st_r   <= s1_st_r;
      s2_sp_r   <= s1_sp_r;
      s2_ring_r <= ring_nxt;
      s2_rsp_r  <= rsp_prod;
      s2_cpct_r <= cpct_prod;
      s2_cpst_r <= cpst_prod;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: ring times trig, round z and the normal
  logic signed [PROD_W-1:0] px_prod, py_prod;

  assign px_prod = s2_ring_r * s2_ct_r;
  assign py_prod = -(s2_ring_r * s2_st_r);

  logic                     s3_act_r, s3_bad_r;
  logic [IDX_W-1:0]         s3_cur_r;
  logic [TEX_W-1:0]         s3_u_r, s3_v_r;
  logic signed [PROD_W-1:0] s3_px_r, s3_py_r;
  logic [POS_W-1:0]         s3_pz_r;
  logic [NORM_W-1:0]        s3_nx_r, s3_ny_r, s3_nz_r;

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_act_r <= s2_act_r;
      s3_bad_r <= s2_bad_r;
      s3_cur_r <= s2_cur_r;
      s3_u_r   <= s2_u_r;
      s3_v_r   <= s2_v_r;
      s3_px_r  <= px_prod;
      s3_py_r  <= py_prod;
      s3_pz_r  <= sat_pos(rnd_half(PROD_W'(s2_rsp_r), 14));
      s3_nx_r  <= sat_norm(rnd_half(PROD_W'(s2_cpct_r), 14));
      s3_ny_r  <= sat_norm(rnd_half(-PROD_W'(s2_cpst_r), 14));
      s3_nz_r  <= NORM_W'(s2_sp_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: output register; quads replay six corners from it
  logic              s3_vert;
  logic              s4_quad_r, s4_bad_r;
  logic [IDX_W-1:0]  s4_cur_r;
  logic [POS_W-1:0]  s4_px_r, s4_py_r, s4_pz_r;
  logic [NORM_W-1:0] s4_nx_r, s4_ny_r, s4_nz_r;
  logic [TEX_W-1:0]  s4_u_r, s4_v_r;

  assign s3_vert = !s3_act_r && !s3_bad_r;

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_quad_r <= s3_act_r && !s3_bad_r;
      s4_bad_r  <= s3_bad_r;
      s4_cur_r  <= s3_bad_r ? '0 : s3_cur_r;
      s4_px_r   <= s3_vert ? sat_pos(rnd_half(s3_px_r, 28)) : '0;
      s4_py_r   <= s3_vert ? sat_pos(rnd_half(s3_py_r, 28)) : '0;
      s4_pz_r   <= s3_vert ? s3_pz_r : '0;
      s4_nx_r   <= s3_vert ? s3_nx_r : '0;
      s4_ny_r   <= s3_vert ? s3_ny_r : '0;
      s4_nz_r   <= s3_vert ? s3_nz_r : '0;
      s4_u_r    <= s3_vert ? s3_u_r : '0;
      s4_v_r    <= s3_vert ? s3_v_r : '0;
    end
  end

  logic [IDX_W-1:0] corner_idx;

  assign corner_idx = s4_cur_r + (s4_quad_r ? CORNER_OFS[beat_r] : '0);
  assign out_last   = !s4_quad_r || (beat_r == BEAT_W'(QUAD_BEATS - 1));

  assign out_tlast = out_last;
  assign out_tuser = s4_bad_r;
  assign out_tdata = {4'b0, VIDX_W'(corner_idx), s4_v_r, s4_u_r,
                      s4_nz_r, s4_ny_r, s4_nx_r, s4_pz_r, s4_py_r, s4_px_r};

endmodule

`default_nettype wire

// File: design/tmg_checker.sv
// Port-level checks for the torus mesh generator, bound to the top level.
`default_nettype none

module tmg_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [tmg_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire logic                              out_tlast,
  input wire logic                              out_tuser
);

  import tmg_pkg::*;

  // A stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tlast) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // An out-of-grid cell is a single all-zero beat
  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == '0)
    else $error("bad cell beat not single or not zero");

  // Corners other than the last carry only an index
  a_corner_only_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[OUT_IDX_LSB-1:0] == '0 && !out_tuser)
    else $error("quad corner carries vertex data");

  // Quad corners follow one another without a gap
  a_corner_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a quad run");

endmodule

bind torus_mesh_generator tmg_checker u_tmg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
